>>> rtl/fba_pkg.sv
// shared types, constants and defaults for the frame bitmap allocator
package fba_pkg;

    // parameter defaults
    localparam int MAX_FRAMES_DEF = 4096;
    localparam int WORD_BITS_DEF  = 32;

    // fixed field widths
    localparam int CFG_W        = 13;
    localparam int FRAME_W      = 12;
    localparam int FIELD_FRAMES = 4096;

    // reset value of the frame count register
    localparam logic [CFG_W-1:0] MEM_FRAMES_RST = 13'd4096;

    // request codes
    typedef enum logic [1:0] {
        ACT_ALLOC = 2'd0,
        ACT_FREE  = 2'd1,
        ACT_MARK  = 2'd2,
        ACT_TEST  = 2'd3
    } t_action;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_HAS_FRAME = 2'd1,
        ST_NO_FREE   = 2'd2
    } t_status;

    // controller states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_REJECT,
        S_READ,
        S_MODIFY,
        S_SCAN
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic clr_we;
        logic ld_item;
        logic scan_init;
        logic scan_run;
        logic mod_we;
        logic res_rej;
        logic res_item;
        logic res_scan;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic    clr_last;
        t_action in_action;
        logic    in_has_frame;
        t_action action;
        logic    scan_done;
    } t_dp_sts;

endpackage

>>> rtl/fba_ram.sv
// generic single write port, single read port ram with registered read
module fba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/fba_ctrl.sv
// controller state machine of the frame bitmap allocator
module fba_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  fba_pkg::t_dp_sts i_sts,
    output fba_pkg::t_dp_cmd o_cmd
);

    fba_pkg::t_state r_state;
    fba_pkg::t_state n_state;

    // state register, reset starts the clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fba_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fba_pkg::S_CLEAR: begin
                if (i_sts.clr_last) begin
                    n_state = fba_pkg::S_IDLE;
                end
            end
            fba_pkg::S_IDLE: begin
                if (start) begin
                    priority if (i_sts.in_action == fba_pkg::ACT_ALLOC && i_sts.in_has_frame)
                    begin
                        n_state = fba_pkg::S_REJECT;
                    end else if (i_sts.in_action == fba_pkg::ACT_ALLOC) begin
                        n_state = fba_pkg::S_SCAN;
                    end else begin
                        n_state = fba_pkg::S_READ;
                    end
                end
            end
            fba_pkg::S_REJECT: n_state = fba_pkg::S_IDLE;
            fba_pkg::S_READ:   n_state = fba_pkg::S_MODIFY;
            fba_pkg::S_MODIFY: n_state = fba_pkg::S_IDLE;
            fba_pkg::S_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = fba_pkg::S_IDLE;
                end
            end
            default: n_state = fba_pkg::S_CLEAR;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            fba_pkg::S_CLEAR: begin
                o_cmd.clr_we = 1'b1;
            end
            fba_pkg::S_IDLE: begin
                o_cmd.ld_item   = start;
                o_cmd.scan_init = start;
            end
            fba_pkg::S_REJECT: begin
                o_cmd.res_rej = 1'b1;
            end
            fba_pkg::S_READ: begin
                o_cmd = '0;
            end
            fba_pkg::S_MODIFY: begin
                o_cmd.mod_we   = (i_sts.action == fba_pkg::ACT_FREE) ||
                                 (i_sts.action == fba_pkg::ACT_MARK);
                o_cmd.res_item = 1'b1;
            end
            fba_pkg::S_SCAN: begin
                o_cmd.scan_run = 1'b1;
                o_cmd.res_scan = i_sts.scan_done;
            end
            default: o_cmd = '0;
        endcase
    end

    assign busy = (r_state != fba_pkg::S_IDLE);

endmodule

>>> rtl/fba_datapath.sv
// datapath of the frame bitmap allocator: bitmap ram, scan logic, result registers
module fba_datapath #(
    parameter int MAX_FRAMES = fba_pkg::MAX_FRAMES_DEF,
    parameter int WORD_BITS  = fba_pkg::WORD_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  fba_pkg::t_dp_cmd            i_cmd,
    output fba_pkg::t_dp_sts            o_sts,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [fba_pkg::CFG_W-1:0]   i_cfg_memory_frames,
    input  logic [1:0]                  i_action,
    input  logic [fba_pkg::FRAME_W-1:0] i_frame_index,
    input  logic                        i_supervisor,
    input  logic                        i_read_write,
    output logic                        o_done,
    output logic [1:0]                  o_status,
    output logic [fba_pkg::FRAME_W-1:0] o_result_frame,
    output logic                        o_present,
    output logic                        o_user_flag,
    output logic                        o_writable_flag,
    output logic                        o_frame_busy
);

    localparam int NUM_WORDS    = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int WA_W         = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int BI_W         = $clog2(WORD_BITS);
    localparam int CFG_W        = fba_pkg::CFG_W;
    localparam int FRAME_W      = fba_pkg::FRAME_W;
    localparam int SEARCH_LIMIT = (MAX_FRAMES < fba_pkg::FIELD_FRAMES) ?
                                  MAX_FRAMES : fba_pkg::FIELD_FRAMES;
    localparam int BW_W         = CFG_W - BI_W;
    localparam int CMP_W        = ((WA_W > BW_W) ? WA_W : BW_W) + 1;
    localparam int FRM_W        = ((WA_W + BI_W) > FRAME_W) ? (WA_W + BI_W) : FRAME_W;
    localparam logic [WA_W-1:0] LAST_WORD = WA_W'(NUM_WORDS - 1);

    // item and configuration registers
    fba_pkg::t_action     r_action;
    logic [FRAME_W-1:0]   r_fi;
    logic                 r_kern;
    logic                 r_wr;
    logic [CFG_W-1:0]     r_mem_frames;

    // clear and scan counters
    logic [WA_W-1:0]      r_clr_addr;
    logic [WA_W-1:0]      r_scan_addr;
    logic [WA_W-1:0]      r_chk_addr;
    logic                 r_chk_vld;

    // result registers
    logic                 r_done;
    fba_pkg::t_status     r_status;
    logic [FRAME_W-1:0]   r_frame;
    logic                 r_present;
    logic                 r_user;
    logic                 r_wrf;
    logic                 r_fbusy;

    // ram ports
    logic                 w_we;
    logic [WA_W-1:0]      w_wa;
    logic [WORD_BITS-1:0] w_wd;
    logic [WA_W-1:0]      w_ra;
    logic [WORD_BITS-1:0] w_rd;

    // decoded values
    logic [CFG_W-1:0]     w_bound;
    logic [BW_W-1:0]      w_full;
    logic [BI_W-1:0]      w_rem;
    logic [WORD_BITS-1:0] w_mask;
    logic [WORD_BITS-1:0] w_avail;
    logic [WORD_BITS-1:0] w_iso;
    logic [BI_W-1:0]      w_enc;
    logic                 w_hit;
    logic                 w_end;
    logic [FRM_W-1:0]     w_found;
    logic [WA_W-1:0]      w_item_word;
    logic [BI_W-1:0]      w_item_bit;
    logic [WORD_BITS-1:0] w_item_onehot;
    logic                 w_in_map;

    fba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_WORDS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_we),
        .i_wr_addr (w_wa),
        .i_wr_data (w_wd),
        .i_rd_addr (w_ra),
        .o_rd_data (w_rd)
    );

    // configuration register, always ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_frames <= fba_pkg::MEM_FRAMES_RST;
        end else if (i_cfg_valid) begin
            r_mem_frames <= i_cfg_memory_frames;
        end
    end
    assign o_cfg_ready = 1'b1;

    // capture the item on an accepted transfer
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_item) begin
            r_action <= fba_pkg::t_action'(i_action);
            r_fi     <= i_frame_index;
            r_kern   <= i_supervisor;
            r_wr     <= i_read_write;
        end
    end

    // clearing pass counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_we && r_clr_addr != LAST_WORD) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // scan address pipeline, one word read per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_addr <= '0;
            r_chk_addr  <= '0;
            r_chk_vld   <= 1'b0;
        end else if (i_cmd.scan_init) begin
            r_scan_addr <= '0;
            r_chk_vld   <= 1'b0;
        end else if (i_cmd.scan_run) begin
            r_chk_addr <= r_scan_addr;
            r_chk_vld  <= 1'b1;
            if (r_scan_addr != LAST_WORD) begin
                r_scan_addr <= r_scan_addr + 1'b1;
            end
        end
    end

    // search bound split into whole words and a remainder
    assign w_bound = (r_mem_frames < CFG_W'(SEARCH_LIMIT)) ? r_mem_frames
                                                           : CFG_W'(SEARCH_LIMIT);
    assign w_full  = w_bound[CFG_W-1:BI_W];
    assign w_rem   = w_bound[BI_W-1:0];

    // in-bound bit mask of the word under check
    always_comb begin
        priority if (CMP_W'(r_chk_addr) < CMP_W'(w_full)) begin
            w_mask = '1;
        end else if (CMP_W'(r_chk_addr) == CMP_W'(w_full)) begin
            w_mask = ~({WORD_BITS{1'b1}} << w_rem);
        end else begin
            w_mask = '0;
        end
    end

    // lowest free bit: isolate then encode
    assign w_avail = ~w_rd & w_mask;
    assign w_iso   = w_avail & (~w_avail + WORD_BITS'(1));
    always_comb begin
        w_enc = '0;
        for (int b = 0; b < WORD_BITS; b++) begin
            if (w_iso[b]) begin
                w_enc = w_enc | BI_W'(b);
            end
        end
    end
    assign w_hit   = r_chk_vld && (|w_avail);
    assign w_end   = r_chk_vld && ((CMP_W'(r_chk_addr) >= CMP_W'(w_full)) ||
                                   (r_chk_addr == LAST_WORD));
    assign w_found = (FRM_W'(r_chk_addr) << BI_W) | FRM_W'(w_enc);

    // single-frame access decode
    assign w_item_word   = WA_W'(r_fi >> BI_W);
    assign w_item_bit    = r_fi[BI_W-1:0];
    assign w_item_onehot = WORD_BITS'(1) << w_item_bit;
    assign w_in_map      = (32'(r_fi) < 32'(MAX_FRAMES));

    // ram read address
    assign w_ra = i_cmd.scan_run ? r_scan_addr : w_item_word;

    // ram write: clearing pass, alloc write-back, free or mark update
    always_comb begin
        w_we = 1'b0;
        w_wa = r_clr_addr;
        w_wd = '0;
        if (i_cmd.clr_we) begin
            w_we = 1'b1;
        end else if (i_cmd.res_scan && w_hit) begin
            w_we = 1'b1;
            w_wa = r_chk_addr;
            w_wd = w_rd | w_iso;
        end else if (i_cmd.mod_we && w_in_map) begin
            w_we = 1'b1;
            w_wa = w_item_word;
            w_wd = (r_action == fba_pkg::ACT_FREE) ? (w_rd & ~w_item_onehot)
                                                   : (w_rd | w_item_onehot);
        end
    end

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.res_rej || i_cmd.res_item || i_cmd.res_scan;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_rej) begin
            r_status  <= fba_pkg::ST_HAS_FRAME;
            r_frame   <= r_fi;
            r_present <= 1'b0;
            r_user    <= 1'b0;
            r_wrf     <= 1'b0;
            r_fbusy   <= 1'b0;
        end else if (i_cmd.res_item) begin
            r_status  <= fba_pkg::ST_OK;
            r_frame   <= (r_action == fba_pkg::ACT_FREE) ? '0 : r_fi;
            r_present <= 1'b0;
            r_user    <= 1'b0;
            r_wrf     <= 1'b0;
            r_fbusy   <= (r_action == fba_pkg::ACT_TEST) && w_in_map && w_rd[w_item_bit];
        end else if (i_cmd.res_scan) begin
            r_status  <= w_hit ? fba_pkg::ST_OK : fba_pkg::ST_NO_FREE;
            r_frame   <= w_hit ? w_found[FRAME_W-1:0] : r_fi;
            r_present <= w_hit;
            r_user    <= w_hit && !r_kern;
            r_wrf     <= w_hit && r_wr;
            r_fbusy   <= 1'b0;
        end
    end

    // status to the controller
    assign o_sts.clr_last     = (r_clr_addr == LAST_WORD);
    assign o_sts.in_action    = fba_pkg::t_action'(i_action);
    assign o_sts.in_has_frame = (i_frame_index != '0);
    assign o_sts.action       = r_action;
    assign o_sts.scan_done    = w_hit || w_end;

    assign o_done          = r_done;
    assign o_status        = r_status;
    assign o_result_frame  = r_frame;
    assign o_present       = r_present;
    assign o_user_flag     = r_user;
    assign o_writable_flag = r_wrf;
    assign o_frame_busy    = r_fbusy;

endmodule

>>> rtl/frame_bitmap_allocator.sv
// top level of the frame bitmap allocator
//
// Keeps one used bit per 4 KiB frame in a RAM of WORD_BITS-wide words
// (WORD_BITS a power of two). A request transfers at a rising edge with start
// high and busy low; action, frame_index, supervisor and read_write are
// sampled there. Exactly one result follows, shown for one cycle with o_done
// high; the receiver cannot stall it and must take it in that cycle.
// From the accepting edge, a request passes these states before o_done:
//   alloc on a page that already has a frame: S_REJECT
//   free, mark, test: S_READ (RAM read), S_MODIFY (write-back for free, mark)
//   alloc: S_SCAN, one bitmap word read per cycle from the RAM port, until a
//   free bit or the search bound, at most 128 words with the defaults
// busy drops in the o_done cycle, so the next request may transfer then.
// The frame count register is written over its own valid/ready channel,
// always ready. The user must write it only while the block is idle; the
// block itself does not enforce this. After reset a clearing pass writes
// every bitmap word to zero, one word a cycle (128 words by default); busy
// stays high until it ends. Configuration writes are taken during the pass.
module frame_bitmap_allocator #(
    parameter int MAX_FRAMES = fba_pkg::MAX_FRAMES_DEF,
    parameter int WORD_BITS  = fba_pkg::WORD_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_action,
    input  logic [fba_pkg::FRAME_W-1:0] i_frame_index,
    input  logic                        i_supervisor,
    input  logic                        i_read_write,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [fba_pkg::CFG_W-1:0]   i_cfg_memory_frames,
    output logic                        o_done,
    output logic [1:0]                  o_status,
    output logic [fba_pkg::FRAME_W-1:0] o_result_frame,
    output logic                        o_present,
    output logic                        o_user_flag,
    output logic                        o_writable_flag,
    output logic                        o_frame_busy
);

    fba_pkg::t_dp_cmd w_cmd;
    fba_pkg::t_dp_sts w_sts;

    // controller
    fba_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    // datapath
    fba_datapath #(
        .MAX_FRAMES (MAX_FRAMES),
        .WORD_BITS  (WORD_BITS)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .o_sts               (w_sts),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_memory_frames (i_cfg_memory_frames),
        .i_action            (i_action),
        .i_frame_index       (i_frame_index),
        .i_supervisor        (i_supervisor),
        .i_read_write        (i_read_write),
        .o_done              (o_done),
        .o_status            (o_status),
        .o_result_frame      (o_result_frame),
        .o_present           (o_present),
        .o_user_flag         (o_user_flag),
        .o_writable_flag     (o_writable_flag),
        .o_frame_busy        (o_frame_busy)
    );

endmodule

>>> rtl/fba_checker.sv
// port-level checker for the frame bitmap allocator, with its bind
module fba_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        o_done,
    input logic [1:0]                  o_status,
    input logic                        o_present,
    input logic                        o_user_flag,
    input logic                        o_writable_flag
);

    // an accepted transfer makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    // results never come in consecutive cycles
    a_done_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe high in two consecutive cycles");

    // the block is idle when a result is shown
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("busy high while a result is shown");

    // status is a legal code
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_status == fba_pkg::ST_OK || o_status == fba_pkg::ST_HAS_FRAME ||
                    o_status == fba_pkg::ST_NO_FREE))
        else $error("illegal status code");

    // failed results carry no page flags
    a_fail_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != fba_pkg::ST_OK) |->
            (!o_present && !o_user_flag && !o_writable_flag))
        else $error("page flags set on a failed result");

endmodule

bind frame_bitmap_allocator fba_checker u_fba_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_done          (o_done),
    .o_status        (o_status),
    .o_present       (o_present),
    .o_user_flag     (o_user_flag),
    .o_writable_flag (o_writable_flag)
);

>>> test/tb.sv
// testbench for the frame bitmap allocator: request driver, bitmap predictor and result checks
`timescale 1ns / 100ps

module tb;
    import fba_pkg::*;

    // one page entry as returned by the block
    typedef struct {
        t_status             status;
        logic [FRAME_W-1:0]  frame;
        logic                present;
        logic                user;
        logic                writable;
        logic                used;
    } t_page_entry;

    // bitmap predictor plus queue of page entries still owed by the block
    class t_frame_map_checker;
        bit                  frame_used [FIELD_FRAMES];
        logic [CFG_W-1:0]    frame_count = MEM_FRAMES_RST;
        t_page_entry         pending_entries [$];
        int unsigned         mismatches;
        int unsigned         results_seen;
        int unsigned         action_seen [4];
        int unsigned         alloc_granted;
        int unsigned         alloc_occupied;
        int unsigned         alloc_exhausted;

        // work out the entry for an accepted request and update the bitmap
        function void note_request(t_action act, logic [FRAME_W-1:0] idx, logic kern,
                                   logic wr);
            t_page_entry e;
            int          bound;
            int          f;
            e.status   = ST_OK;
            e.frame    = idx;
            e.present  = 1'b0;
            e.user     = 1'b0;
            e.writable = 1'b0;
            e.used     = 1'b0;
            action_seen[act]++;
            case (act)
                ACT_ALLOC: begin
                    if (idx != 0) begin
                        e.status = ST_HAS_FRAME;
                        alloc_occupied++;
                    end else begin
                        // search bound is the smallest of frame count, map size and field range
                        bound = frame_count;
                        if (bound > MAX_FRAMES_DEF) bound = MAX_FRAMES_DEF;
                        if (bound > FIELD_FRAMES) bound = FIELD_FRAMES;
                        f = 0;
                        while (f < bound && frame_used[f]) f++;
                        if (f >= bound) begin
                            e.status = ST_NO_FREE;
                            alloc_exhausted++;
                        end else begin
                            frame_used[f] = 1'b1;
                            e.frame    = f[FRAME_W-1:0];
                            e.present  = 1'b1;
                            e.user     = ~kern;
                            e.writable = wr;
                            alloc_granted++;
                        end
                    end
                end
                ACT_FREE: begin
                    frame_used[idx] = 1'b0;
                    e.frame = '0;
                end
                ACT_MARK: frame_used[idx] = 1'b1;
                default: e.used = frame_used[idx];
            endcase
            pending_entries.push_back(e);
        endfunction

        task report_mismatch(string what, int got, int want);
            mismatches++;
            $display("%0t: mismatch on %s: got %0d, predicted %0d", $time, what, got, want);
        endtask

        // compare one returned entry with the oldest pending one
        task check_result(logic [1:0] st, logic [FRAME_W-1:0] frame, logic present,
                          logic user, logic writable, logic used);
            t_page_entry e;
            if (pending_entries.size() == 0) begin
                report_mismatch("result with nothing pending", frame, 0);
                return;
            end
            e = pending_entries.pop_front();
            results_seen++;
            if (st !== e.status) report_mismatch("status", st, e.status);
            if (frame !== e.frame) report_mismatch("result_frame", frame, e.frame);
            if (present !== e.present) report_mismatch("present", present, e.present);
            if (user !== e.user) report_mismatch("user_flag", user, e.user);
            if (writable !== e.writable) report_mismatch("writable_flag", writable, e.writable);
            if (used !== e.used) report_mismatch("frame_busy", used, e.used);
        endtask
    endclass

    logic                i_clk;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [1:0]          i_action = ACT_TEST;
    logic [FRAME_W-1:0]  i_frame_index = '0;
    logic                i_supervisor = 1'b0;
    logic                i_read_write = 1'b0;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [CFG_W-1:0]    i_cfg_memory_frames = MEM_FRAMES_RST;
    logic                o_done;
    logic [1:0]          o_status;
    logic [FRAME_W-1:0]  o_result_frame;
    logic                o_present;
    logic                o_user_flag;
    logic                o_writable_flag;
    logic                o_frame_busy;

    t_frame_map_checker  chk;
    int                  frame_bound = FIELD_FRAMES;
    int                  settings_used = 1;

    frame_bitmap_allocator dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_action            (i_action),
        .i_frame_index       (i_frame_index),
        .i_supervisor        (i_supervisor),
        .i_read_write        (i_read_write),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_memory_frames (i_cfg_memory_frames),
        .o_done              (o_done),
        .o_status            (o_status),
        .o_result_frame      (o_result_frame),
        .o_present           (o_present),
        .o_user_flag         (o_user_flag),
        .o_writable_flag     (o_writable_flag),
        .o_frame_busy        (o_frame_busy)
    );

    // 8 ns clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // run limit well above the slowest legal run
    initial begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_done)
            chk.check_result(o_status, o_result_frame, o_present, o_user_flag,
                             o_writable_flag, o_frame_busy);
    end

    // one request transfer
    task send_request(t_action act, logic [FRAME_W-1:0] idx, logic kern, logic wr);
        @(negedge i_clk);
        start         <= 1'b1;
        i_action      <= act;
        i_frame_index <= idx;
        i_supervisor  <= kern;
        i_read_write  <= wr;
        do @(posedge i_clk); while (busy);
        chk.note_request(act, idx, kern, wr);
    endtask

    // random sender gaps, now and then a long one
    task idle_sender(int pct);
        if ($urandom_range(99) < pct) begin
            @(negedge i_clk);
            start <= 1'b0;
            if ($urandom_range(99) < 4)
                repeat ($urandom_range(1, 150)) @(negedge i_clk);
            while ($urandom_range(99) < pct) @(negedge i_clk);
        end
    endtask

    // hold requests until every pending entry has come back
    task drain_results;
        @(negedge i_clk);
        start <= 1'b0;
        while (chk.pending_entries.size() != 0) @(posedge i_clk);
    endtask

    // frame count register transfer, block idle
    task write_frame_count(logic [CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid         <= 1'b1;
        i_cfg_memory_frames <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        chk.frame_count = value;
        frame_bound = (value > FIELD_FRAMES) ? FIELD_FRAMES : value;
        settings_used++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // target frame: mostly below or just past the search bound, sometimes anywhere
    function automatic logic [FRAME_W-1:0] pick_frame();
        int lim;
        lim = frame_bound + 8;
        if (lim > FIELD_FRAMES) lim = FIELD_FRAMES;
        if ($urandom_range(99) < 75)
            return FRAME_W'($urandom_range(0, lim - 1));
        return FRAME_W'($urandom_range(0, FIELD_FRAMES - 1));
    endfunction

    task random_request;
        int                 r;
        logic [FRAME_W-1:0] idx;
        r = $urandom_range(99);
        if (r < 45) begin
            idx = ($urandom_range(99) < 15) ? FRAME_W'($urandom_range(1, FIELD_FRAMES - 1)) : '0;
            send_request(ACT_ALLOC, idx, 1'($urandom), 1'($urandom));
        end else if (r < 65) begin
            send_request(ACT_FREE, pick_frame(), 1'($urandom), 1'($urandom));
        end else if (r < 80) begin
            send_request(ACT_MARK, pick_frame(), 1'($urandom), 1'($urandom));
        end else begin
            send_request(ACT_TEST, pick_frame(), 1'($urandom), 1'($urandom));
        end
    endtask

    // stimulus
    initial begin
        int settings [10];
        int idle_pct [4];
        int ph;
        int n;
        int value;
        settings = '{1, 0, 8191, 33, 4096, 4097, 64, 4095, -1, 5};
        idle_pct = '{0, 49, 0, 32};
        chk = new;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: flags, occupied page, frame zero and top frame
        send_request(ACT_TEST, 12'd0, 1'b0, 1'b0);
        send_request(ACT_TEST, 12'hFFF, 1'b1, 1'b1);
        send_request(ACT_ALLOC, 12'hFFF, 1'b1, 1'b1);
        send_request(ACT_ALLOC, 12'd0, 1'b0, 1'b0);
        send_request(ACT_ALLOC, 12'd0, 1'b1, 1'b1);
        send_request(ACT_ALLOC, 12'd0, 1'b0, 1'b1);
        send_request(ACT_ALLOC, 12'd0, 1'b1, 1'b0);
        send_request(ACT_TEST, 12'd2, 1'b0, 1'b0);
        send_request(ACT_FREE, 12'd0, 1'b1, 1'b1);
        send_request(ACT_TEST, 12'd0, 1'b0, 1'b0);
        send_request(ACT_ALLOC, 12'd0, 1'b0, 1'b1);
        send_request(ACT_MARK, 12'hFFF, 1'b0, 1'b0);
        send_request(ACT_TEST, 12'hFFF, 1'b0, 1'b0);
        send_request(ACT_FREE, 12'hFFF, 1'b0, 1'b0);
        send_request(ACT_TEST, 12'hFFF, 1'b0, 1'b0);
        send_request(ACT_MARK, 12'd4, 1'b0, 1'b0);
        send_request(ACT_FREE, 12'd2, 1'b0, 1'b0);
        send_request(ACT_ALLOC, 12'd0, 1'b1, 1'b1);
        send_request(ACT_ALLOC, 12'd0, 1'b0, 1'b0);
        send_request(ACT_ALLOC, 12'hAAA, 1'b0, 1'b1);
        send_request(ACT_FREE, 12'h555, 1'b1, 1'b0);
        send_request(ACT_TEST, 12'd4, 1'b0, 1'b0);

        // random phases, the first on the reset frame count
        for (ph = 0; ph <= 10; ph++) begin
            if (ph > 0) begin
                drain_results();
                value = settings[ph - 1];
                if (value < 0) value = $urandom_range(2, 300);
                write_frame_count(CFG_W'(value));
            end
            for (n = 0; n < 139; n++) begin
                idle_sender(idle_pct[ph % 4]);
                random_request();
                if ($urandom_range(99) < 2) drain_results();
            end
        end

        drain_results();
        repeat (140) @(posedge i_clk);

        $display("covered %0d alloc, %0d free, %0d mark, %0d test requests over %0d frame counts",
                 chk.action_seen[ACT_ALLOC], chk.action_seen[ACT_FREE],
                 chk.action_seen[ACT_MARK], chk.action_seen[ACT_TEST], settings_used);
        $display("allocs: %0d granted, %0d on occupied page, %0d exhausted; %0d checked, %0d bad",
                 chk.alloc_granted, chk.alloc_occupied, chk.alloc_exhausted,
                 chk.results_seen, chk.mismatches);
        if (chk.mismatches == 0 && chk.pending_entries.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
